// ----- sv/sps_pkg.sv -----
package sps_pkg;

  // Field widths fixed by the packet format
  localparam int unsigned TIME_W = 40;
  localparam int unsigned DIV_W  = 39;  // size * 8e6 stays below 2^39
  localparam int unsigned RATE_W = 32;

  localparam logic [TIME_W-1:0] TIME_MAX     = {TIME_W{1'b1}};
  localparam logic [DIV_W-1:0]  BIT_US_SCALE = DIV_W'(64'd8000000);

  // Reset values of the configuration registers
  localparam logic [3:0]        LIMIT_RST = 4'd5;
  localparam logic [RATE_W-1:0] RATE_RST  = 32'd1000;
  localparam logic [TIME_W-1:0] END_RST   = 40'd100000000;

  // Register indexes (byte address / 8)
  localparam logic [1:0] REG_QUEUE_LIMIT = 2'd0;
  localparam logic [1:0] REG_LINK_RATE   = 2'd1;
  localparam logic [1:0] REG_END_TIME    = 2'd2;

  // Commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic              command;
    logic [15:0]       packet_id;
    logic [1:0]        packet_class;
    logic [15:0]       packet_size;
    logic [TIME_W-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              sent;
    logic [15:0]       sent_id;
    logic [1:0]        sent_class;
    logic [15:0]       sent_size;
    logic [TIME_W-1:0] finish_us;
    logic [3:0]        occupancy;
    logic              link_busy;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

endpackage

// ----- sv/strict_priority_packet_scheduler.sv -----
// Sequence: a push goes from the execute state to the done state, which loads the result
// into the output register once it is free, and so does a tick that sends nothing; a tick
// that sends runs the read, divide and finish states in between, the bit-serial divider
// giving one quotient bit per cycle over 39 bits. Throughput: one item at a time; the next
// transfer is taken once the result is in the output register.
// Reset: asynchronous, active low; clears queues and busy time, loads default configuration.
module strict_priority_packet_scheduler
  import sps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int NUM_CLASSES = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output result_t     out_data_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int CLS_W     = $clog2(NUM_CLASSES);
  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int STEP_W    = $clog2(DIV_W);

  state_e state_q, state_d;

  item_t             item_q;
  result_t           res_q;
  result_t           out_q;
  logic              out_valid_q;

  logic [SLOT_W-1:0] head_q [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_q  [NUM_CLASSES];
  logic [CNT_W-1:0]  total_q;
  logic [TIME_W-1:0] busy_q;

  logic [3:0]        limit_q;
  logic [RATE_W-1:0] rate_q;
  logic [TIME_W-1:0] end_q;

  logic [CLS_W-1:0]  sel_cls_q;
  logic [31:0]       mem [MEM_DEPTH];
  logic [31:0]       rd_q;

  logic [DIV_W-1:0]  quo_q;
  logic [RATE_W-1:0] rem_q;
  logic [STEP_W-1:0] step_q;

  // Control decoded from the sequencer
  logic in_xfer, cfg_wr, push_en, pop_en, load_out;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[4:3])
      REG_QUEUE_LIMIT: prdata = {60'd0, limit_q};
      REG_LINK_RATE:   prdata = {32'd0, rate_q};
      REG_END_TIME:    prdata = {24'd0, end_q};
      default:         prdata = 64'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Queue bookkeeping for the item under work
  logic              push_ok, tick_ok;
  logic [CLS_W-1:0]  pick_cls, acc_cls;
  logic [SLOT_W-1:0] head_sel, head_nxt, slot;
  logic [CNT_W-1:0]  cnt_sel;
  logic [CNT_W:0]    tail_sum;
  logic [ADDR_W-1:0] mem_addr;

  assign push_ok = (item_q.command == CMD_PUSH)
                 && (32'(item_q.packet_class) < NUM_CLASSES)
                 && (32'(total_q) < 32'(limit_q))
                 && (32'(total_q) < QUEUE_DEPTH);

  assign tick_ok = (item_q.command == CMD_TICK)
                 && !(item_q.now_us < busy_q)
                 && (total_q != '0)
                 && !(busy_q > end_q);

  // Highest non-empty class wins
  always_comb begin
    pick_cls = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cnt_q[c] != '0) begin
        pick_cls = CLS_W'(c);
      end
    end
  end

  assign acc_cls  = (item_q.command == CMD_TICK) ? pick_cls : CLS_W'(item_q.packet_class);
  assign head_sel = head_q[acc_cls];
  assign cnt_sel  = cnt_q[acc_cls];

  // Tail slot wraps once at most since head and count both stay within depth
  always_comb begin
    tail_sum = (CNT_W+1)'(head_sel) + (CNT_W+1)'(cnt_sel);
    if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    slot = SLOT_W'(tail_sum);
  end

  assign head_nxt = (head_sel == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + SLOT_W'(1);

  assign mem_addr = ADDR_W'(acc_cls) * ADDR_W'(QUEUE_DEPTH)
                  + ADDR_W'((item_q.command == CMD_TICK) ? head_sel : slot);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = tick_ok ? ST_READ : ST_DONE;
      ST_READ: state_d = ST_DIV;
      ST_DIV:  if (step_q == '0) state_d = ST_FIN;
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_xfer  = 1'b0;
    push_en  = 1'b0;
    pop_en   = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: in_xfer  = in_valid_i;
      ST_EXEC: begin
        push_en = push_ok;
        pop_en  = tick_ok;
      end
      ST_DONE: load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Packet store
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem[mem_addr] <= {item_q.packet_size, item_q.packet_id};
    end
    rd_q <= mem[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // Divider step and finish time
  logic [RATE_W:0]   trial;
  logic              trial_ge;
  logic [TIME_W-1:0] delay, room, fin;

  assign trial    = {rem_q, quo_q[DIV_W-1]};
  assign trial_ge = trial >= {1'b0, rate_q};

  assign delay = (rate_q == '0) ? TIME_MAX : TIME_W'(quo_q);
  assign room  = TIME_MAX - item_q.now_us;
  assign fin   = (delay >= room) ? TIME_MAX : item_q.now_us + delay;

  // Attach occupancy and link state to the finished result
  result_t out_d;

  always_comb begin
    out_d           = res_q;
    out_d.occupancy = 4'(total_q);
    out_d.link_busy = item_q.now_us < busy_q;
  end

  // ---------------------------------------------------------------------------
  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      busy_q      <= '0;
      limit_q     <= LIMIT_RST;
      rate_q      <= RATE_RST;
      end_q       <= END_RST;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;

      // write configuration
      if (cfg_wr) begin
        case (paddr[4:3])
          REG_QUEUE_LIMIT: limit_q <= pwdata[3:0];
          REG_LINK_RATE:   rate_q  <= pwdata[RATE_W-1:0];
          REG_END_TIME:    end_q   <= pwdata[TIME_W-1:0];
          default: ;
        endcase
      end

      // advance queue pointers
      if (push_en) begin
        cnt_q[acc_cls] <= cnt_sel + CNT_W'(1);
        total_q        <= total_q + CNT_W'(1);
      end
      if (pop_en) begin
        head_q[acc_cls] <= head_nxt;
        cnt_q[acc_cls]  <= cnt_sel - CNT_W'(1);
        total_q         <= total_q - CNT_W'(1);
      end

      if (state_q == ST_FIN) begin
        busy_q <= fin;
      end

      // hold the result until the output transfer
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
      res_q  <= '0;
    end

    if (state_q == ST_EXEC) begin
      res_q.accepted <= push_ok;
      sel_cls_q      <= pick_cls;
    end

    // scale size to bit-microseconds and seed the divider
    if (state_q == ST_READ) begin
      res_q.sent       <= 1'b1;
      res_q.sent_id    <= rd_q[15:0];
      res_q.sent_size  <= rd_q[31:16];
      res_q.sent_class <= 2'(sel_cls_q);
      quo_q            <= DIV_W'(rd_q[31:16]) * BIT_US_SCALE;
      rem_q            <= '0;
      step_q           <= STEP_W'(DIV_W - 1);
    end

    // one restoring-division step per cycle
    if (state_q == ST_DIV) begin
      rem_q  <= trial_ge ? RATE_W'(trial - {1'b0, rate_q}) : trial[RATE_W-1:0];
      quo_q  <= {quo_q[DIV_W-2:0], trial_ge};
      step_q <= step_q - STEP_W'(1);
    end

    if (state_q == ST_FIN) begin
      res_q.finish_us <= fin;
    end

    if (load_out) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- sv/sps_checker.sv -----
module sps_checker
  import sps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_o,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input result_t out_data_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Take one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // A step either stores or sends, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.accepted && out_data_o.sent))
    else $error("result both accepted and sent");

  // Without a send the packet fields stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.sent |->
      out_data_o.sent_id == '0 && out_data_o.sent_size == '0 &&
      out_data_o.finish_us == '0)
    else $error("packet fields set without a send");

  // Occupancy stays within the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.occupancy) <= QUEUE_DEPTH)
    else $error("occupancy above buffer depth");

endmodule

bind strict_priority_packet_scheduler sps_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_sps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
